// File: design/bu2_pkg.sv
// Shared types and constants of the bilinear 2x upscaler.
// Depends on nothing; every other file of the block but bu2_ram refers to it by scoped names.
package bu2_pkg;

    localparam int PIX_W       = 16;
    localparam int COORD_W     = 13;
    localparam int ROW_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int MAX_HEIGHT  = 4096;

    localparam logic [CFG_IDX_W-1:0]  CFG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_SRC_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 13'd480;

    // Output 2x2 blocks an item can release, in emission order.
    typedef enum logic [1:0] {
        BLK_MAIN,
        BLK_RIGHT,
        BLK_BOTTOM,
        BLK_CORNER
    } t_blk;

    // Position inside one 2x2 block; bit 0 is the right column, bit 1 the lower row.
    typedef enum logic [1:0] {
        Q_TL,
        Q_TR,
        Q_BL,
        Q_BR
    } t_quad;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // One classified item: its neighborhood, doubled coordinates and enabled blocks.
    typedef struct packed {
        logic [PIX_W-1:0]   ul;
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   lf;
        logic [PIX_W-1:0]   cur;
        logic [COORD_W-1:0] rr;
        logic [COORD_W-1:0] cc;
        logic [3:0]         blk_en;
    } t_job;

endpackage

// File: design/bu2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the line buffer of the upscaler.
module bu2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bu2_front.sv
// Front end of the upscaler: configuration registers, raster counters, line buffer
// and neighbor registers. Builds one job per item. Depends on bu2_pkg and bu2_ram.
module bu2_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bu2_pkg::t_cfg_wr          i_cfg,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [bu2_pkg::PIX_W-1:0] i_pixel,
    input  logic [bu2_pkg::QCNT_W-1:0] i_q_count,
    output logic                      o_push,
    output bu2_pkg::t_job             o_job
);

    localparam int PW = (PIXEL_BITS < bu2_pkg::PIX_W) ? PIXEL_BITS : bu2_pkg::PIX_W;
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    logic [bu2_pkg::CFG_DATA_W-1:0] r_src_width;
    logic [bu2_pkg::CFG_DATA_W-1:0] r_src_height;
    logic [CW-1:0]                  r_col;
    logic [bu2_pkg::ROW_W-1:0]      r_row;
    logic                           r_s2_valid;

    logic [PW-1:0]                  r_s2_cur;
    logic [bu2_pkg::COORD_W-1:0]    r_s2_rr;
    logic [bu2_pkg::COORD_W-1:0]    r_s2_cc;
    logic [3:0]                     r_s2_en;
    logic [PW-1:0]                  r_left;
    logic [PW-1:0]                  r_upleft;

    logic [CW-1:0]                  col_last;
    logic [bu2_pkg::ROW_W-1:0]      row_last;
    logic                           accept;
    logic [bu2_pkg::QCNT_W:0]       pending;
    logic [PW-1:0]                  cur;
    logic [PW-1:0]                  up;
    logic                           at_col_last;
    logic                           at_row_last;
    logic [3:0]                     en;

    // Effective last column and row after clamping the programmed size.
    always_comb begin
        if (r_src_width < 13'd2) begin
            col_last = CW'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(r_src_width - 13'd1);
        end
        if (r_src_height < 13'd2) begin
            row_last = bu2_pkg::ROW_W'(1);
        end else if (32'(r_src_height) > 32'(bu2_pkg::MAX_HEIGHT)) begin
            row_last = bu2_pkg::ROW_W'(bu2_pkg::MAX_HEIGHT - 1);
        end else begin
            row_last = bu2_pkg::ROW_W'(r_src_height - 13'd1);
        end
    end

    // Room is kept for the item in the second stage plus the one accepted now.
    assign pending    = {1'b0, i_q_count} + {{bu2_pkg::QCNT_W{1'b0}}, r_s2_valid};
    assign o_s_tready = pending < (bu2_pkg::QCNT_W + 1)'(bu2_pkg::QUEUE_DEPTH);
    assign accept     = i_s_tvalid && o_s_tready;
    assign cur        = i_pixel[PW-1:0];

    assign at_col_last = (r_col == col_last);
    assign at_row_last = (r_row == row_last);

    always_comb begin
        en = '0;
        en[bu2_pkg::BLK_MAIN]   = (r_row != '0) && (r_col != '0);
        en[bu2_pkg::BLK_RIGHT]  = (r_row != '0) && at_col_last;
        en[bu2_pkg::BLK_BOTTOM] = at_row_last && (r_col != '0);
        en[bu2_pkg::BLK_CORNER] = at_row_last && at_col_last;
    end

    bu2_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (cur),
        .i_raddr (r_col),
        .o_rdata (up)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bu2_pkg::RST_SRC_WIDTH;
            r_src_height <= bu2_pkg::RST_SRC_HEIGHT;
            r_col        <= '0;
            r_row        <= '0;
            r_s2_valid   <= 1'b0;
            r_left       <= '0;
            r_upleft     <= '0;
        end else begin
            r_s2_valid <= accept;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    bu2_pkg::CFG_SRC_WIDTH: begin
                        r_src_width <= i_cfg.data;
                    end
                    bu2_pkg::CFG_SRC_HEIGHT: begin
                        r_src_height <= i_cfg.data;
                    end
                    default: begin
                        r_src_width <= r_src_width;
                    end
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (at_col_last) begin
                    r_col <= '0;
                    r_row <= at_row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_s2_valid) begin
                r_upleft <= up;
                r_left   <= r_s2_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_cur <= cur;
            r_s2_rr  <= bu2_pkg::COORD_W'({r_row, 1'b0});
            r_s2_cc  <= bu2_pkg::COORD_W'({r_col, 1'b0});
            r_s2_en  <= en;
        end
    end

    assign o_push       = r_s2_valid;
    assign o_job.ul     = bu2_pkg::PIX_W'(r_upleft);
    assign o_job.up     = bu2_pkg::PIX_W'(up);
    assign o_job.lf     = bu2_pkg::PIX_W'(r_left);
    assign o_job.cur    = bu2_pkg::PIX_W'(r_s2_cur);
    assign o_job.rr     = r_s2_rr;
    assign o_job.cc     = r_s2_cc;
    assign o_job.blk_en = r_s2_en;

endmodule

// File: design/bu2_queue.sv
// Short job queue between the front end and the emitter of the upscaler.
// Depends on bu2_pkg for the job type and depth.
module bu2_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  bu2_pkg::t_job              i_job,
    input  logic                       i_pop,
    output logic                       o_valid,
    output bu2_pkg::t_job              o_job,
    output logic [bu2_pkg::QCNT_W-1:0] o_count
);

    bu2_pkg::t_job                 r_slot [bu2_pkg::QUEUE_DEPTH];
    logic [bu2_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [bu2_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [bu2_pkg::QCNT_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: design/bu2_back.sv
// Emitter of the upscaler: walks the enabled 2x2 blocks of one job, one output
// pixel per cycle unless stalled, into a registered output stage. Depends on bu2_pkg.
module bu2_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  bu2_pkg::t_job               i_q_job,
    output logic                        o_pop,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [bu2_pkg::PIX_W-1:0]   o_value,
    output logic [bu2_pkg::COORD_W-1:0] o_row,
    output logic [bu2_pkg::COORD_W-1:0] o_col,
    output logic                        o_last,
    output logic                        o_frame_end
);

    // Returns {found, index} of the lowest enabled block at or above start.
    function automatic logic [2:0] find_blk(input logic [3:0] en, input logic [2:0] start);
        logic [2:0] res;
        res = '0;
        for (int i = 3; i >= 0; i--) begin
            if (en[i] && (3'(i) >= start)) begin
                res = {1'b1, 2'(i)};
            end
        end
        return res;
    endfunction

    logic                        r_busy;
    logic                        r_m_valid;
    bu2_pkg::t_job               r_job;
    bu2_pkg::t_blk               r_blk;
    bu2_pkg::t_quad              r_pix;
    logic [bu2_pkg::PIX_W-1:0]   r_value;
    logic [bu2_pkg::COORD_W-1:0] r_row;
    logic [bu2_pkg::COORD_W-1:0] r_col;
    logic                        r_last;
    logic                        r_frame_end;

    logic                        out_load;
    logic                        emit;
    logic                        take;
    logic                        is_last;
    logic [2:0]                  nxt;
    logic [2:0]                  first;
    logic [bu2_pkg::PIX_W:0]     s_ulup;
    logic [bu2_pkg::PIX_W:0]     s_ullf;
    logic [bu2_pkg::PIX_W:0]     s_upcur;
    logic [bu2_pkg::PIX_W:0]     s_lfcur;
    logic [bu2_pkg::PIX_W+1:0]   s_all;
    logic [bu2_pkg::PIX_W-1:0]   val;
    logic [bu2_pkg::COORD_W-1:0] base_row;
    logic [bu2_pkg::COORD_W-1:0] base_col;

    assign out_load = !r_m_valid || i_m_tready;
    assign emit     = r_busy && out_load;
    assign nxt      = find_blk(r_job.blk_en, 3'(r_blk) + 3'd1);
    assign first    = find_blk(i_q_job.blk_en, 3'd0);
    assign is_last  = !nxt[2] && (r_pix == bu2_pkg::Q_BR);
    assign take     = i_q_valid && (!r_busy || (emit && is_last));
    assign o_pop    = take;

    always_comb begin
        s_ulup  = {1'b0, r_job.ul} + {1'b0, r_job.up};
        s_ullf  = {1'b0, r_job.ul} + {1'b0, r_job.lf};
        s_upcur = {1'b0, r_job.up} + {1'b0, r_job.cur};
        s_lfcur = {1'b0, r_job.lf} + {1'b0, r_job.cur};
        s_all   = {1'b0, s_ulup} + {2'b0, r_job.lf} + {2'b0, r_job.cur};
        val     = '0;
        case (r_blk)
            bu2_pkg::BLK_MAIN: begin
                case (r_pix)
                    bu2_pkg::Q_TL: val = r_job.ul;
                    bu2_pkg::Q_TR: val = s_ulup[bu2_pkg::PIX_W:1];
                    bu2_pkg::Q_BL: val = s_ullf[bu2_pkg::PIX_W:1];
                    bu2_pkg::Q_BR: val = s_all[bu2_pkg::PIX_W+1:2];
                    default:       val = '0;
                endcase
            end
            bu2_pkg::BLK_RIGHT: begin
                case (r_pix)
                    bu2_pkg::Q_TL: val = r_job.up;
                    bu2_pkg::Q_BL: val = s_upcur[bu2_pkg::PIX_W:1];
                    default:       val = '0;
                endcase
            end
            bu2_pkg::BLK_BOTTOM: begin
                case (r_pix)
                    bu2_pkg::Q_TL: val = r_job.lf;
                    bu2_pkg::Q_TR: val = s_lfcur[bu2_pkg::PIX_W:1];
                    default:       val = '0;
                endcase
            end
            bu2_pkg::BLK_CORNER: begin
                val = (r_pix == bu2_pkg::Q_TL) ? r_job.cur : '0;
            end
            default: begin
                val = '0;
            end
        endcase
        // Blocks of the row above sit two output rows up; left blocks two columns left.
        base_row = ((r_blk == bu2_pkg::BLK_MAIN) || (r_blk == bu2_pkg::BLK_RIGHT))
                   ? r_job.rr - 13'd2 : r_job.rr;
        base_col = ((r_blk == bu2_pkg::BLK_MAIN) || (r_blk == bu2_pkg::BLK_BOTTOM))
                   ? r_job.cc - 13'd2 : r_job.cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= emit;
            end
            if (take) begin
                r_busy <= first[2];
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
            r_blk <= bu2_pkg::t_blk'(first[1:0]);
            r_pix <= bu2_pkg::Q_TL;
        end else if (emit) begin
            if (r_pix == bu2_pkg::Q_BR) begin
                r_blk <= bu2_pkg::t_blk'(nxt[1:0]);
                r_pix <= bu2_pkg::Q_TL;
            end else begin
                r_pix <= bu2_pkg::t_quad'(r_pix + 2'd1);
            end
        end
        if (emit) begin
            r_value     <= val;
            r_row       <= base_row + {12'b0, r_pix[1]};
            r_col       <= base_col + {12'b0, r_pix[0]};
            r_last      <= is_last;
            r_frame_end <= is_last && r_job.blk_en[bu2_pkg::BLK_CORNER];
        end
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_value     = r_value;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_last      = r_last;
    assign o_frame_end = r_frame_end;

endmodule

// File: design/bilinear_upscale_by_two.sv
// Top level of the bilinear 2x image upscaler.
// Depends on bu2_pkg, bu2_front (with bu2_ram), bu2_queue and bu2_back.
//
// Source pixels enter in raster order on the slave stream, one item per pixel.
// The master stream carries the doubled image as items tagged with their output
// row and column; tlast marks the final item released by one source pixel and
// tuser marks the final pixel of the output frame. Each output 2x2 block goes out
// as soon as its last source pixel has arrived, so the first source row releases
// nothing; the clamped height keeps it from also being the last row.
// Size registers are written through the plain write port; the user must write
// them only while the stream is idle, which the block does not enforce. Any write
// restarts the frame at column and row zero. Widths are clamped to [2, MAX_WIDTH],
// heights to [2, 4096]. Output runs at one result per cycle while the receiver
// is not stalling, set by the single output register; the next job is taken
// as the last result of the previous one is emitted. The front end keeps accepting
// while the queue of four jobs has room, so a stalled receiver stops the input
// only after the queue fills. Reset restores 640 by 480 and clears all control
// state; the line buffer needs no clearing since it is written before it is used.
module bilinear_upscale_by_two #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // Source stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] pixel
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] value, [28:16] out_row, [41:29] out_col, zeros
    output logic        o_m_tlast,   // last_of_run
    output logic [0:0]  o_m_tuser    // [0] frame_end
);

    bu2_pkg::t_cfg_wr              cfg;
    logic                          q_push;
    bu2_pkg::t_job                 q_in;
    logic                          q_pop;
    logic                          q_valid;
    bu2_pkg::t_job                 q_out;
    logic [bu2_pkg::QCNT_W-1:0]    q_count;
    logic [bu2_pkg::PIX_W-1:0]     out_value;
    logic [bu2_pkg::COORD_W-1:0]   out_row;
    logic [bu2_pkg::COORD_W-1:0]   out_col;
    logic                          out_frame_end;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Counters, line buffer and neighbors; one job per accepted pixel.
    bu2_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_pixel    (i_s_tdata),
        .i_q_count  (q_count),
        .o_push     (q_push),
        .o_job      (q_in)
    );

    bu2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out),
        .o_count (q_count)
    );

    // Emitter: up to sixteen results per job, one per cycle while the output is not stalled.
    bu2_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_out),
        .o_pop       (q_pop),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_value     (out_value),
        .o_row       (out_row),
        .o_col       (out_col),
        .o_last      (o_m_tlast),
        .o_frame_end (out_frame_end)
    );

    assign o_m_tdata = {6'b0, out_col, out_row, out_value};
    assign o_m_tuser = out_frame_end;

`ifndef NO_ASSERTIONS
    // The queue never holds more jobs than it has slots.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= bu2_pkg::QCNT_W'(bu2_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond its depth");

    // A job is never pushed into a full queue unless one leaves in the same cycle.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && (q_count == bu2_pkg::QCNT_W'(bu2_pkg::QUEUE_DEPTH)) |-> q_pop)
        else $error("job pushed into a full queue");

    // The end of the frame is always the last result of its source pixel.
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("frame end without last of run");

    // Nothing is popped from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job popped from an empty queue");
`endif

endmodule
